[rtl/assert_macros.svh]
// assertion helpers used by the port-level checker kmh_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define KMH_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled in reset
`define KMH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/kmh_pkg.sv]
// ----------------------------------------------------------------------------
// kmh_pkg
// Shared types and constants of the keyed max-heap accumulator.
// ----------------------------------------------------------------------------
package kmh_pkg;

    localparam int DEF_HEAP_DEPTH = 64;
    localparam int DEF_KEY_BITS   = 32;
    localparam int TOTAL_BITS     = 31;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_POP = 1'b1;

    typedef enum logic [1:0] {
        ST_ADDED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_UP,
        S_UP_CMP,
        S_POP_RD0,
        S_POP_RDL,
        S_POP_CAP,
        S_DN,
        S_DN_RDR,
        S_DN_CMP,
        S_FIN
    } t_state;

endpackage

[rtl/kmh_if.sv]
// ----------------------------------------------------------------------------
// kmh_in_if / kmh_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface kmh_in_if #(
    parameter int KEY_BITS = kmh_pkg::DEF_KEY_BITS
);
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [KEY_BITS-1:0]         key;
    logic [kmh_pkg::TOTAL_BITS-1:0] amount;

    modport source(output valid, kind, key, amount, input ready);
    modport sink(input valid, kind, key, amount, output ready);
endinterface

interface kmh_out_if #(
    parameter int KEY_BITS = kmh_pkg::DEF_KEY_BITS,
    parameter int OCC_BITS = 7
);
    logic                        valid;
    logic                        ready;
    logic [KEY_BITS-1:0]         out_key;
    logic [kmh_pkg::TOTAL_BITS-1:0] out_total;
    logic [1:0]                  status;
    logic [OCC_BITS-1:0]         occupancy;

    modport source(output valid, out_key, out_total, status, occupancy, input ready);
    modport sink(input valid, out_key, out_total, status, occupancy, output ready);
endinterface

[rtl/kmh_ram.sv]
// ----------------------------------------------------------------------------
// kmh_ram
// Single-clock entry store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kmh_ram #(
    parameter int DEPTH = kmh_pkg::DEF_HEAP_DEPTH,
    parameter int DW    = kmh_pkg::DEF_KEY_BITS + kmh_pkg::TOTAL_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/kmh_ctrl.sv]
// ----------------------------------------------------------------------------
// kmh_ctrl
// Sequencer for key search, sift-up and sift-down over the entry store.
// ----------------------------------------------------------------------------
module kmh_ctrl #(
    parameter int HEAP_DEPTH = kmh_pkg::DEF_HEAP_DEPTH,
    parameter int KEY_BITS   = kmh_pkg::DEF_KEY_BITS,
    parameter int AW         = $clog2(HEAP_DEPTH),
    parameter int CW         = $clog2(HEAP_DEPTH + 1),
    parameter int DW         = KEY_BITS + kmh_pkg::TOTAL_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kmh_in_if.sink        i_in,
    kmh_out_if.source     o_res,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [DW-1:0] o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [DW-1:0] i_mem_rdata
);
    localparam int TB = kmh_pkg::TOTAL_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

    kmh_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_scan, n_scan;
    logic            r_hv, n_hv;
    logic            r_ov, n_ov;
    logic [AW-1:0]   r_hidx, n_hidx;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_pidx, n_pidx;
    logic [KEY_BITS-1:0] r_ik, n_ik, r_ck, n_ck, r_lk, n_lk, r_fk, n_fk, r_ok, n_ok;
    logic [TB-1:0]   r_iam, n_iam, r_ct, n_ct, r_lt, n_lt, r_ft, n_ft, r_ot, n_ot;
    kmh_pkg::t_status r_fs, n_fs, r_os, n_os;
    logic [CW-1:0]   r_oo, n_oo;

    logic [KEY_BITS-1:0] rd_key;
    logic [TB-1:0]       rd_tot;
    logic [TB:0]         sum;
    logic [AW+1:0]       lchild, rchild, cnt_ext;
    logic                right_exists, pick_r;
    logic [KEY_BITS-1:0] cand_k;
    logic [TB-1:0]       cand_t;

    assign rd_key  = i_mem_rdata[DW-1:TB];
    assign rd_tot  = i_mem_rdata[TB-1:0];
    assign sum     = {1'b0, rd_tot} + {1'b0, r_iam};
    assign lchild  = {1'b0, r_idx, 1'b1};
    assign rchild  = lchild + 1'b1;
    assign cnt_ext = (AW+2)'(r_cnt);
    assign right_exists = rchild < cnt_ext;
    // right child wins unless left is strictly greater or right is missing
    assign pick_r  = right_exists && !(r_lt > rd_tot);
    assign cand_k  = pick_r ? rd_key : r_lk;
    assign cand_t  = pick_r ? rd_tot : r_lt;

    assign i_in.ready      = (r_state == kmh_pkg::S_IDLE);
    assign o_res.valid     = r_ov;
    assign o_res.out_key   = r_ok;
    assign o_res.out_total = r_ot;
    assign o_res.status    = r_os;
    assign o_res.occupancy = r_oo;

    // next state and memory commands
    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;   n_scan = r_scan; n_hv = 1'b0;
        n_ov = r_ov;        n_hidx = r_hidx; n_idx = r_idx;   n_pidx = r_pidx;
        n_ik = r_ik;        n_ck = r_ck;     n_lk = r_lk;     n_fk = r_fk;
        n_ok = r_ok;        n_iam = r_iam;   n_ct = r_ct;     n_lt = r_lt;
        n_ft = r_ft;        n_ot = r_ot;     n_fs = r_fs;     n_os = r_os;
        n_oo = r_oo;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = {r_ck, r_ct};
        o_mem_raddr = '0;

        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            kmh_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_ik = i_in.key;
                    n_iam = i_in.amount;
                    n_fk = '0;
                    n_ft = '0;
                    if (i_in.kind == kmh_pkg::KIND_ADD) begin
                        n_scan = '0;
                        n_state = kmh_pkg::S_SEARCH;
                    end else if (r_cnt == '0) begin
                        n_fs = kmh_pkg::ST_EMPTY;
                        n_state = kmh_pkg::S_FIN;
                    end else begin
                        n_state = kmh_pkg::S_POP_RD0;
                    end
                end
            end
            // one read issued and one key compared per cycle
            kmh_pkg::S_SEARCH: begin
                o_mem_raddr = r_scan[AW-1:0];
                n_hv = r_scan < r_cnt;
                n_hidx = r_scan[AW-1:0];
                if (r_scan < r_cnt) begin
                    n_scan = r_scan + 1'b1;
                end
                if (r_hv && rd_key == r_ik) begin
                    n_idx = r_hidx;
                    n_ck = r_ik;
                    n_ct = sum[TB] ? kmh_pkg::TOTAL_MAX : sum[TB-1:0];
                    n_fs = kmh_pkg::ST_ADDED;
                    n_state = kmh_pkg::S_UP;
                end else if (r_cnt == '0 || (r_hv && CW'(r_hidx) == r_cnt - 1'b1)) begin
                    if (r_cnt == DEPTH_C) begin
                        n_fs = kmh_pkg::ST_FULL;
                        n_state = kmh_pkg::S_FIN;
                    end else begin
                        n_idx = r_cnt[AW-1:0];
                        n_ck = r_ik;
                        n_ct = r_iam;
                        n_cnt = r_cnt + 1'b1;
                        n_fs = kmh_pkg::ST_ADDED;
                        n_state = kmh_pkg::S_UP;
                    end
                end
            end
            // sift-up: read parent of the hole
            kmh_pkg::S_UP: begin
                if (r_idx == '0) begin
                    o_mem_we = 1'b1;
                    n_state = kmh_pkg::S_FIN;
                end else begin
                    n_pidx = (r_idx - 1'b1) >> 1;
                    o_mem_raddr = (r_idx - 1'b1) >> 1;
                    n_state = kmh_pkg::S_UP_CMP;
                end
            end
            kmh_pkg::S_UP_CMP: begin
                o_mem_we = 1'b1;
                if (r_ct > rd_tot) begin
                    o_mem_wdata = i_mem_rdata;
                    n_idx = r_pidx;
                    n_state = kmh_pkg::S_UP;
                end else begin
                    n_state = kmh_pkg::S_FIN;
                end
            end
            // pop: fetch root then last entry
            kmh_pkg::S_POP_RD0: begin
                o_mem_raddr = '0;
                n_state = kmh_pkg::S_POP_RDL;
            end
            kmh_pkg::S_POP_RDL: begin
                o_mem_raddr = AW'(r_cnt - 1'b1);
                n_fk = rd_key;
                n_ft = rd_tot;
                n_fs = kmh_pkg::ST_POPPED;
                n_state = kmh_pkg::S_POP_CAP;
            end
            kmh_pkg::S_POP_CAP: begin
                n_ck = rd_key;
                n_ct = rd_tot;
                n_cnt = r_cnt - 1'b1;
                n_idx = '0;
                n_state = (r_cnt == CW'(1)) ? kmh_pkg::S_FIN : kmh_pkg::S_DN;
            end
            // sift-down: read left then right child
            kmh_pkg::S_DN: begin
                if (lchild >= cnt_ext) begin
                    o_mem_we = 1'b1;
                    n_state = kmh_pkg::S_FIN;
                end else begin
                    o_mem_raddr = lchild[AW-1:0];
                    n_state = kmh_pkg::S_DN_RDR;
                end
            end
            kmh_pkg::S_DN_RDR: begin
                o_mem_raddr = rchild[AW-1:0];
                n_lk = rd_key;
                n_lt = rd_tot;
                n_state = kmh_pkg::S_DN_CMP;
            end
            kmh_pkg::S_DN_CMP: begin
                o_mem_we = 1'b1;
                if (cand_t > r_ct) begin
                    o_mem_wdata = {cand_k, cand_t};
                    n_idx = pick_r ? rchild[AW-1:0] : lchild[AW-1:0];
                    n_state = kmh_pkg::S_DN;
                end else begin
                    n_state = kmh_pkg::S_FIN;
                end
            end
            // hand the result beat to the output register
            kmh_pkg::S_FIN: begin
                if (!r_ov || o_res.ready) begin
                    n_ov = 1'b1;
                    n_ok = r_fk;
                    n_ot = r_ft;
                    n_os = r_fs;
                    n_oo = r_cnt;
                    n_state = kmh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kmh_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmh_pkg::S_IDLE;
            r_cnt <= '0;
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_hv <= n_hv;
            r_ov <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan <= n_scan; r_hidx <= n_hidx; r_idx <= n_idx; r_pidx <= n_pidx;
        r_ik <= n_ik;     r_ck <= n_ck;     r_lk <= n_lk;   r_fk <= n_fk;
        r_ok <= n_ok;     r_iam <= n_iam;   r_ct <= n_ct;   r_lt <= n_lt;
        r_ft <= n_ft;     r_ot <= n_ot;     r_fs <= n_fs;   r_os <= n_os;
        r_oo <= n_oo;
    end
endmodule

[rtl/keyed_max_heap_accumulator.sv]
// Add: scans the held entries for the key, then sifts up, then posts the result.
// Pop: reads the root and the last entry, then sifts down, then posts the result.
// Requests are taken one at a time, only in the idle state, once the previous result
// has been posted to the output register.
// Reset: synchronous active-low; clears entry count, sequencer and output valid;
// the entry store is not cleared.
// ----------------------------------------------------------------------------
// keyed_max_heap_accumulator
// Keyed max-heap of (key, total) entries with add-to-key and pop-max.
// ----------------------------------------------------------------------------
module keyed_max_heap_accumulator #(
    parameter int HEAP_DEPTH = kmh_pkg::DEF_HEAP_DEPTH,
    parameter int KEY_BITS   = kmh_pkg::DEF_KEY_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kmh_in_if.sink    i_in,
    kmh_out_if.source o_res
);
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int DW = KEY_BITS + kmh_pkg::TOTAL_BITS;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    // sequencer
    kmh_ctrl #(
        .HEAP_DEPTH(HEAP_DEPTH), .KEY_BITS(KEY_BITS), .AW(AW), .CW(CW), .DW(DW)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .o_res(o_res),
        .o_mem_we(mem_we), .o_mem_waddr(mem_waddr), .o_mem_wdata(mem_wdata),
        .o_mem_raddr(mem_raddr), .i_mem_rdata(mem_rdata)
    );

    // entry store
    kmh_ram #(.DEPTH(HEAP_DEPTH), .DW(DW)) u_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );
endmodule

[rtl/kmh_chk.sv]
// ----------------------------------------------------------------------------
// kmh_chk
// Port-level checks of the keyed max-heap accumulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmh_chk #(
    parameter int HEAP_DEPTH = kmh_pkg::DEF_HEAP_DEPTH,
    parameter int KEY_BITS   = kmh_pkg::DEF_KEY_BITS,
    parameter int CW         = $clog2(HEAP_DEPTH + 1)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [KEY_BITS-1:0]           i_out_key,
    input logic [kmh_pkg::TOTAL_BITS-1:0] i_out_total,
    input logic [1:0]                    i_status,
    input logic [CW-1:0]                 i_occupancy
);
    // a stalled result beat holds
    `KMH_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_key) && $stable(i_out_total) && $stable(i_status))
    // occupancy never passes capacity
    `KMH_ASSERT_IMPLY(a_occ, i_clk, i_rst_n, i_out_valid, i_occupancy <= CW'(HEAP_DEPTH))
    // pop on empty leaves nothing held and returns zeros
    `KMH_ASSERT_IMPLY(a_empty, i_clk, i_rst_n, i_out_valid && i_status == kmh_pkg::ST_EMPTY, i_occupancy == '0 && i_out_key == '0 && i_out_total == '0)
    // add on full only when the heap is full
    `KMH_ASSERT_IMPLY(a_full, i_clk, i_rst_n, i_out_valid && i_status == kmh_pkg::ST_FULL, i_occupancy == CW'(HEAP_DEPTH) && i_out_key == '0)
endmodule

bind keyed_max_heap_accumulator kmh_chk #(
    .HEAP_DEPTH(HEAP_DEPTH), .KEY_BITS(KEY_BITS)
) u_kmh_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_out_valid(o_res.valid), .i_out_ready(o_res.ready),
    .i_out_key(o_res.out_key), .i_out_total(o_res.out_total),
    .i_status(o_res.status), .i_occupancy(o_res.occupancy)
);

[bench/kmh_checker.sv]
// ----------------------------------------------------------------------------
// kmh_checker
// Watches the request and result channels of the keyed max-heap accumulator,
// keeps its own heap of (key, total) entries and compares every result beat
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module kmh_checker #(
    parameter int HEAP_DEPTH = kmh_pkg::DEF_HEAP_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kmh_in_if.sink    i_in,
    kmh_out_if.sink   i_res,
    output int        o_errors,
    output int        o_pending
);

    typedef struct packed {
        logic [31:0]                    key;
        logic [kmh_pkg::TOTAL_BITS-1:0] total;
        kmh_pkg::t_status               status;
        logic [6:0]                     occupancy;
    } t_result;

    logic [31:0]                    heap_key[HEAP_DEPTH];
    logic [kmh_pkg::TOTAL_BITS-1:0] heap_total[HEAP_DEPTH];
    int                             heap_count;
    t_result                        expected_results[$];

    // exchange two heap slots
    function automatic void swap_slots(int a, int b);
        logic [31:0]                    k;
        logic [kmh_pkg::TOTAL_BITS-1:0] t;
        k = heap_key[a];
        t = heap_total[a];
        heap_key[a] = heap_key[b];
        heap_total[a] = heap_total[b];
        heap_key[b] = k;
        heap_total[b] = t;
    endfunction

    // move an entry toward the root while strictly greater than its parent
    function automatic void climb(int idx);
        int p;
        while (idx > 0) begin
            p = (idx - 1) / 2;
            if (heap_total[idx] <= heap_total[p]) break;
            swap_slots(idx, p);
            idx = p;
        end
    endfunction

    // move the root down; absent child is -1, ties go right
    function automatic void sink_root();
        int     idx;
        int     l;
        int     r;
        longint lv;
        longint rv;
        idx = 0;
        while (idx < heap_count) begin
            l = 2 * idx + 1;
            r = 2 * idx + 2;
            if (l >= heap_count) break;
            lv = heap_total[l];
            rv = (r < heap_count) ? longint'(heap_total[r]) : -1;
            if (lv > rv) begin
                if (lv <= heap_total[idx]) break;
                swap_slots(l, idx);
                idx = l;
            end else begin
                if (rv <= heap_total[idx]) break;
                swap_slots(r, idx);
                idx = r;
            end
        end
    endfunction

    // compute the result of one request beat and update the heap
    function automatic t_result apply_request(logic kind, logic [31:0] key,
                                              logic [kmh_pkg::TOTAL_BITS-1:0] amount);
        t_result      res;
        int           hit;
        logic [31:0]  sum;
        res = '0;
        hit = -1;
        if (kind == kmh_pkg::KIND_ADD) begin
            for (int i = 0; i < heap_count; i++)
                if (hit < 0 && heap_key[i] == key) hit = i;
            res.status = kmh_pkg::ST_ADDED;
            if (hit >= 0) begin
                sum = {1'b0, heap_total[hit]} + {1'b0, amount};
                heap_total[hit] = sum[31] ? kmh_pkg::TOTAL_MAX : sum[kmh_pkg::TOTAL_BITS-1:0];
                climb(hit);
            end else if (heap_count >= HEAP_DEPTH) begin
                res.status = kmh_pkg::ST_FULL;
            end else begin
                heap_key[heap_count] = key;
                heap_total[heap_count] = amount;
                heap_count++;
                climb(heap_count - 1);
            end
        end else if (heap_count == 0) begin
            res.status = kmh_pkg::ST_EMPTY;
        end else begin
            res.key = heap_key[0];
            res.total = heap_total[0];
            res.status = kmh_pkg::ST_POPPED;
            heap_count--;
            heap_key[0] = heap_key[heap_count];
            heap_total[0] = heap_total[heap_count];
            sink_root();
        end
        res.occupancy = 7'(heap_count);
        return res;
    endfunction

    assign o_pending = expected_results.size();

    // predict on request beats, compare on result beats
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            heap_count = 0;
            o_errors <= 0;
            expected_results.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                expected_results.push_back(apply_request(i_in.kind, i_in.key, i_in.amount));
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result key=%h total=%h status=%0d occ=%0d",
                             $time, i_res.out_key, i_res.out_total, i_res.status,
                             i_res.occupancy);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.out_key !== want.key || i_res.out_total !== want.total ||
                        i_res.status !== want.status || i_res.occupancy !== want.occupancy) begin
                        $display("%0t: mismatch expected key=%h total=%h status=%0d occ=%0d",
                                 $time, want.key, want.total, want.status, want.occupancy);
                        $display("%0t:          actual   key=%h total=%h status=%0d occ=%0d",
                                 $time, i_res.out_key, i_res.out_total, i_res.status,
                                 i_res.occupancy);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives add and pop requests into the keyed max-heap accumulator with random
// gaps and result back-pressure, including filling the heap to overflow and
// draining it past empty; verdict comes from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH     = kmh_pkg::DEF_HEAP_DEPTH;
    localparam int MAX_CYCLE = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycle_count = 0;
    logic hold_off = 1'b0;

    kmh_in_if  req_ch();
    kmh_out_if res_ch();

    keyed_max_heap_accumulator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_ch.sink), .o_res(res_ch.source)
    );

    kmh_checker #(.HEAP_DEPTH(DEPTH)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_ch.sink), .i_res(res_ch.sink),
        .o_errors(errors), .o_pending(pending)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // short gaps mostly, a long one now and then
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side ready with random stalls, plus a long hold-off on request
    initial begin
        int n;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            n = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
            if (n > 0) begin
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // one request beat, then an optional gap
    task automatic send(logic kind, logic [31:0] key, logic [kmh_pkg::TOTAL_BITS-1:0] amount,
                        bit with_gap);
        int n;
        req_ch.valid <= 1'b1;
        req_ch.kind <= kind;
        req_ch.key <= key;
        req_ch.amount <= amount;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        n = with_gap ? gap_len() : 0;
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    logic [31:0] key_pool[16];

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.kind <= kmh_pkg::KIND_ADD;
        req_ch.key <= '0;
        req_ch.amount <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pop, extremes, saturation, ties, key update
        send(kmh_pkg::KIND_POP, 32'hFFFF_FFFF, kmh_pkg::TOTAL_MAX, 1'b1);
        send(kmh_pkg::KIND_ADD, 32'h0, 31'h0, 1'b1);
        send(kmh_pkg::KIND_ADD, 32'hFFFF_FFFF, kmh_pkg::TOTAL_MAX, 1'b1);
        send(kmh_pkg::KIND_ADD, 32'hFFFF_FFFF, kmh_pkg::TOTAL_MAX, 1'b1);
        send(kmh_pkg::KIND_ADD, 32'h0, kmh_pkg::TOTAL_MAX, 1'b1);
        send(kmh_pkg::KIND_ADD, 32'h5, 31'd7, 1'b1);
        send(kmh_pkg::KIND_ADD, 32'h6, 31'd7, 1'b1);
        send(kmh_pkg::KIND_ADD, 32'h7, 31'd7, 1'b0);
        send(kmh_pkg::KIND_ADD, 32'h5, 31'd1, 1'b1);
        send(kmh_pkg::KIND_ADD, 32'hAAAA_5555, 31'h5555_AAAA, 1'b1);
        repeat (8) send(kmh_pkg::KIND_POP, $urandom, 31'($urandom), 1'b1);
        wait_drained();

        // fill past full with the result side held off
        hold_off = 1'b1;
        for (int i = 0; i < DEPTH + 3; i++)
            send(kmh_pkg::KIND_ADD, 32'h1000 + i, 31'($urandom_range(0, 50)), 1'b0);
        hold_off = 1'b0;
        send(kmh_pkg::KIND_ADD, 32'h1002, 31'd1000, 1'b1);
        wait_drained();
        for (int i = 0; i < DEPTH + 2; i++)
            send(kmh_pkg::KIND_POP, $urandom, 31'($urandom), 1'($urandom_range(0, 1)));
        wait_drained();

        // random: mostly adds on a small key pool, duplicates likely
        foreach (key_pool[i]) key_pool[i] = $urandom;
        for (int i = 0; i < 210; i++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 35)
                send(kmh_pkg::KIND_POP, $urandom, 31'($urandom), 1'b1);
            else if (r < 80)
                send(kmh_pkg::KIND_ADD, key_pool[$urandom_range(0, 15)],
                     ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 99)),
                     1'b1);
            else
                send(kmh_pkg::KIND_ADD, $urandom, 31'($urandom), 1'b1);
        end
        wait_drained();

        // random near full: new keys dominate
        for (int i = 0; i < 90; i++)
            send($urandom_range(0, 5) == 0 ? kmh_pkg::KIND_POP : kmh_pkg::KIND_ADD, $urandom,
                 31'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        wait_drained();
        repeat (200) @(posedge i_clk);

        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
